### rtl/core/muxed_cell_voltage_frame_decoder_defines.svh
// Assertion macros used by the checker file mcvd_checker.sv.
`ifndef MUXED_CELL_VOLTAGE_FRAME_DECODER_DEFINES_SVH
`define MUXED_CELL_VOLTAGE_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication.
`define MCVD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MCVD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/mcvd_pkg.sv
`default_nettype none
package mcvd_pkg;

    localparam int          GROUPS_DEF   = 24;
    localparam logic [10:0] CELL_FRAME_ID = 11'h6F2;

    localparam int ID_W      = 11;
    localparam int DATA_W    = 64;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 32;

    localparam int GROUP_W  = 5;
    localparam int RAW_W    = 14;
    localparam int READINGS = 4;
    localparam int IDX_W    = 7;
    localparam int MV_W     = 13;
    localparam int COUNT_W  = 7;
    localparam int ZSEEN_W  = 2;

    // floor(raw * 20000 / 65536)
    localparam logic [14:0] MV_SCALE = 15'd20000;
    localparam int          PROD_W   = 29;
    localparam int          MV_SHIFT = 16;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd14;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 7'd127;

    localparam logic [ZSEEN_W-1:0] ZSEEN_FIXED = 2'd3;
    localparam logic [ZSEEN_W-1:0] ZSEEN_ARM   = 2'd2;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [GROUP_W-1:0]                group;
        logic [READINGS-1:0][RAW_W-1:0]    raw;
        logic [COUNT_W-1:0]                count;
        logic                              fixed;
    } mcvd_entry_t;

    typedef struct packed {
        logic        valid;
        mcvd_entry_t entry;
    } mcvd_push_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } mcvd_qstat_t;

endpackage
`default_nettype wire

### rtl/core/mcvd_queue.sv
`default_nettype none
module mcvd_queue
    import mcvd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire mcvd_push_t  push,
    input  wire logic        pop,
    output mcvd_qstat_t      stat,
    output mcvd_entry_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(DEPTH - 1);

    mcvd_entry_t        mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               do_push, do_pop;

    assign stat.full     = (cnt_reg == DEPTH_C);
    assign stat.nonempty = (cnt_reg != '0);
    assign head          = mem[rd_ptr_reg];
    assign do_push       = push.valid && !stat.full;
    assign do_pop        = pop && stat.nonempty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/core/mcvd_front.sv
`default_nettype none
module mcvd_front
    import mcvd_pkg::*;
#(
    parameter int GROUPS = GROUPS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire mcvd_qstat_t          qstat,
    output mcvd_push_t                push
);

    localparam logic [7:0] GROUP_LIMIT = 8'(GROUPS);

    logic [ID_W-1:0]    frame_id;
    logic [DATA_W-1:0]  frame_data;
    logic [7:0]         group_byte;
    logic [GROUP_W-1:0] group;
    logic               hit, take;

    logic [GROUP_W-1:0] highest_reg, highest_next;
    logic [ZSEEN_W-1:0] zseen_reg, zseen_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               fixed;
    logic [COUNT_W:0]   count_raw;

    assign frame_id   = s_tdata[ID_W-1:0];
    assign frame_data = s_tdata[ID_W+DATA_W-1:ID_W];
    assign group_byte = frame_data[7:0];
    assign group      = group_byte[GROUP_W-1:0];
    assign hit        = (frame_id == CELL_FRAME_ID) && (group_byte < GROUP_LIMIT);
    assign s_tready   = !qstat.full;
    assign take       = s_tvalid && s_tready && hit;

    always_comb begin
        highest_next = highest_reg;
        zseen_next   = zseen_reg;
        count_next   = count_reg;
        fixed        = 1'b0;
        count_raw    = '0;
        if (group > highest_reg) begin
            highest_next = group;
        end
        if (zseen_reg < ZSEEN_ARM && group == '0) begin
            zseen_next = zseen_reg + 1'b1;
            if (zseen_next == ZSEEN_ARM) begin
                count_raw  = {1'b0, highest_next, 2'b00} + (COUNT_W+1)'(READINGS);
                count_next = count_raw[COUNT_W] ? COUNT_MAX : count_raw[COUNT_W-1:0];
                zseen_next = ZSEEN_FIXED;
                fixed      = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            highest_reg <= '0;
            zseen_reg   <= '0;
            count_reg   <= COUNT_RESET;
        end else if (take) begin
            highest_reg <= highest_next;
            zseen_reg   <= zseen_next;
            count_reg   <= count_next;
        end
    end

    always_comb begin
        push.valid       = take;
        push.entry.group = group;
        push.entry.count = count_next;
        push.entry.fixed = fixed;
        for (int k = 0; k < READINGS; k++) begin
            push.entry.raw[k] = frame_data[8 + RAW_W*k +: RAW_W];
        end
    end

endmodule
`default_nettype wire

### rtl/core/mcvd_back.sv
`default_nettype none
module mcvd_back
    import mcvd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire mcvd_qstat_t           qstat,
    input  wire mcvd_entry_t           head,
    output logic                       pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);

    localparam int POS_W = $clog2(READINGS);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(READINGS - 1);

    logic [POS_W-1:0]      pos_reg;
    logic                  valid_reg;
    logic [M_TDATA_W-1:0]  tdata_reg;
    logic                  tuser_reg, tlast_reg;
    logic                  load, step;
    logic [RAW_W-1:0]      raw_sel;
    logic [PROD_W-1:0]     prod;
    logic [MV_W-1:0]       mv;
    logic [IDX_W-1:0]      idx;

    assign load    = !valid_reg || m_tready;
    assign step    = load && qstat.nonempty;
    assign pop     = step && (pos_reg == LAST_POS);
    assign raw_sel = head.raw[pos_reg];
    assign prod    = PROD_W'(raw_sel) * PROD_W'(MV_SCALE);
    assign mv      = prod[MV_SHIFT +: MV_W];
    assign idx     = IDX_W'({head.group, pos_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end else if (load) begin
            valid_reg <= qstat.nonempty;
            if (qstat.nonempty) begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            tdata_reg <= M_TDATA_W'({head.count, mv, idx});
            tuser_reg <= head.fixed;
            tlast_reg <= (pos_reg == LAST_POS);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tlast  = tlast_reg;

endmodule
`default_nettype wire

### rtl/core/muxed_cell_voltage_frame_decoder.sv
// Channel  Dir  tdata (low bit up)                                   tuser            tlast
// s_       in   frame_id[10:0], frame_data[74:11], zero pad to 80     -                -
// m_       out  cell_index[6:0], cell_millivolts[19:7],               count_fixed_now  last_of_frame
//               cells_in_pack[26:20], zero pad to 32
//
// A cell frame yields four readings, one per cycle while m_tready is high, set by the single
// 14x15 scaling multiplier in the back end; other frames yield none.
// The front end takes a frame per cycle while the queue has room; the frame is written into
// the queue, and its first reading is then registered into the back end's output register.
// m_tready low holds the output register; the queue then fills and s_tready drops.
// Synchronous reset clears the queue and sets the cell count to 14.
`default_nettype none
module muxed_cell_voltage_frame_decoder
    import mcvd_pkg::*;
#(
    parameter int GROUPS = GROUPS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // frame_id, frame_data
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // cell_index, cell_millivolts, cells_in_pack
    output logic                       m_tuser,   // count_fixed_now
    output logic                       m_tlast
);

    mcvd_push_t  push;
    mcvd_qstat_t qstat;
    mcvd_entry_t head;
    logic        pop;

    mcvd_front #(
        .GROUPS (GROUPS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .qstat    (qstat),
        .push     (push)
    );

    mcvd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .stat    (qstat),
        .head    (head)
    );

    mcvd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .qstat    (qstat),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

### rtl/core/mcvd_checker.sv
`default_nettype none
`include "muxed_cell_voltage_frame_decoder_defines.svh"
module mcvd_checker
    import mcvd_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata,
    input wire logic                  m_tuser,
    input wire logic                  m_tlast
);

    `MCVD_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "item dropped while stalled")
    `MCVD_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable({m_tdata, m_tuser, m_tlast}), "item changed while stalled")
    `MCVD_ASSERT_NEXT(a_frame_burst, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid, "gap inside a frame's readings")
    `MCVD_ASSERT_IMPLY(a_last_pos, aclk, aresetn, m_tvalid, (m_tdata[1:0] == 2'b11) == m_tlast, "last flag not on fourth reading")
    `MCVD_ASSERT_IMPLY(a_mv_range, aclk, aresetn, m_tvalid, m_tdata[19:7] <= 13'd4999, "millivolts out of range")

endmodule

bind muxed_cell_voltage_frame_decoder mcvd_checker u_mcvd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

### dv/cell_reading_checker.sv
module cell_reading_checker
    import mcvd_pkg::*;
#(
    parameter int GROUPS = GROUPS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [M_TDATA_W-1:0]  m_tdata,
    input  wire logic                  m_tuser,
    input  wire logic                  m_tlast,
    output int                         errors,
    output int                         readings_due,
    output int                         readings_checked
);

    typedef struct packed {
        logic [IDX_W-1:0]   cell_index;
        logic [MV_W-1:0]    millivolts;
        logic [COUNT_W-1:0] cells_in_pack;
        logic               count_fixed_now;
        logic               last_of_frame;
    } cell_reading_t;

    cell_reading_t      readings_due_q[$];
    logic [GROUP_W-1:0] top_group;
    logic [ZSEEN_W-1:0] group0_arrivals;
    logic [COUNT_W-1:0] pack_cells;

    function automatic logic [MV_W-1:0] raw_to_millivolts(logic [RAW_W-1:0] raw);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(raw) * PROD_W'(20000);
        return prod[PROD_W-1:MV_SHIFT];
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        errors++;
    endtask

    task automatic predict_readings(logic [S_TDATA_W-1:0] beat);
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] data;
        logic [7:0]        grp;
        logic              fixed;
        int                cnt;
        cell_reading_t     r;
        id    = beat[ID_W-1:0];
        data  = beat[ID_W +: DATA_W];
        grp   = data[7:0];
        fixed = 1'b0;
        if (id != CELL_FRAME_ID || grp >= GROUPS) return;
        if (grp > 8'(top_group)) top_group = grp[GROUP_W-1:0];
        if (group0_arrivals < ZSEEN_ARM && grp == 8'd0) begin
            group0_arrivals++;
            if (group0_arrivals == ZSEEN_ARM) begin
                cnt = 4 * top_group + 4;
                pack_cells = (cnt > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(cnt);
                group0_arrivals = ZSEEN_FIXED;
                fixed = 1'b1;
            end
        end
        for (int k = 0; k < READINGS; k++) begin
            r.cell_index      = IDX_W'(grp * 4 + k);
            r.millivolts      = raw_to_millivolts(data[8 + RAW_W*k +: RAW_W]);
            r.cells_in_pack   = pack_cells;
            r.count_fixed_now = fixed;
            r.last_of_frame   = (k == READINGS - 1);
            readings_due_q.push_back(r);
        end
    endtask

    task automatic check_reading();
        cell_reading_t want;
        if (readings_due_q.size() == 0) begin
            report_mismatch("reading with none due, cell_index", '0, m_tdata[6:0]);
            return;
        end
        want = readings_due_q.pop_front();
        readings_checked++;
        if (m_tdata[6:0] != want.cell_index)
            report_mismatch("cell_index", want.cell_index, m_tdata[6:0]);
        if (m_tdata[19:7] != want.millivolts)
            report_mismatch("cell_millivolts", want.millivolts, m_tdata[19:7]);
        if (m_tdata[26:20] != want.cells_in_pack)
            report_mismatch("cells_in_pack", want.cells_in_pack, m_tdata[26:20]);
        if (m_tuser !== want.count_fixed_now)
            report_mismatch("count_fixed_now", want.count_fixed_now, m_tuser);
        if (m_tlast !== want.last_of_frame)
            report_mismatch("last_of_frame", want.last_of_frame, m_tlast);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            top_group       = '0;
            group0_arrivals = '0;
            pack_cells      = COUNT_RESET;
            readings_due_q.delete();
        end else begin
            if (m_tvalid && m_tready) check_reading();
            if (s_tvalid && s_tready) predict_readings(s_tdata);
        end
        readings_due <= readings_due_q.size();
    end

endmodule

### dv/tb_muxed_cell_voltage_frame_decoder.sv
module tb_muxed_cell_voltage_frame_decoder;
    import mcvd_pkg::*;

    localparam int GROUPS      = GROUPS_DEF;
    localparam int RAND_FRAMES = 395;
    localparam int CALM_AFTER  = 330;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 300;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    int errors;
    int readings_due;
    int readings_checked;
    int frames_sent = 0;
    int cell_frames = 0;
    bit idle_on     = 1'b1;
    bit hold_done   = 1'b0;

    always #5 aclk = ~aclk;

    muxed_cell_voltage_frame_decoder #(.GROUPS(GROUPS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    cell_reading_checker #(.GROUPS(GROUPS)) u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .errors(errors), .readings_due(readings_due), .readings_checked(readings_checked)
    );

    function automatic logic [DATA_W-1:0] cell_payload(logic [7:0] grp,
            logic [RAW_W-1:0] r0, logic [RAW_W-1:0] r1,
            logic [RAW_W-1:0] r2, logic [RAW_W-1:0] r3);
        return {r3, r2, r1, r0, grp};
    endfunction

    function automatic logic [DATA_W-1:0] random_payload(logic [7:0] grp);
        logic [DATA_W-1:0] d;
        d = {$urandom, $urandom};
        d[7:0] = grp;
        return d;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_frame(logic [ID_W-1:0] id, logic [DATA_W-1:0] data);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-ID_W-DATA_W){1'b0}}, data, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        frames_sent++;
        if (id == CELL_FRAME_ID && data[7:0] < GROUPS) cell_frames++;
        @(negedge aclk);
    endtask

    // output side: random stalls plus one long hold-off to back up the input
    initial begin
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (!hold_done && frames_sent >= HOLD_AT) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
                m_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int               kind;
        logic [ID_W-1:0]  id;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // non-cell identifiers and out-of-range groups: nothing comes out
        send_frame('0, random_payload(8'd0));
        send_frame('1, '1);
        send_frame(CELL_FRAME_ID ^ 11'd1, random_payload(8'd0));
        send_frame(CELL_FRAME_ID, random_payload(8'(GROUPS)));
        send_frame(CELL_FRAME_ID, '1);
        // first group 0, then count gets fixed at the second one
        send_frame(CELL_FRAME_ID, cell_payload(8'd0, '0, '0, '0, '0));
        send_frame(CELL_FRAME_ID, cell_payload(8'd3, '1, '1, '1, '1));
        send_frame(CELL_FRAME_ID, cell_payload(8'd1, 14'd1, 14'h3FFE, 14'd4, 14'h2000));
        send_frame(CELL_FRAME_ID, random_payload(8'd0));
        // count must stay put from here on
        send_frame(CELL_FRAME_ID, cell_payload(8'(GROUPS-1), '1, '1, '1, '1));
        send_frame(CELL_FRAME_ID, random_payload(8'd0));
        send_frame(CELL_FRAME_ID, cell_payload(8'd12, 14'h1555, 14'h2AAA, 14'd3, 14'd7));
        send_frame(CELL_FRAME_ID, random_payload(8'd0));
        send_frame(CELL_FRAME_ID, random_payload(8'(GROUPS-1)));

        for (int i = 0; i < RAND_FRAMES; i++) begin
            if (frames_sent >= CALM_AFTER) idle_on = 1'b0;
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                id = ID_W'($urandom_range(0, 2047));
                if (id == CELL_FRAME_ID) id = id ^ 11'd1;
                send_frame(id, {$urandom, $urandom});
            end else if (kind == 1) begin
                send_frame(CELL_FRAME_ID, random_payload(8'($urandom_range(GROUPS, 255))));
            end else begin
                send_frame(CELL_FRAME_ID, random_payload(8'($urandom_range(0, GROUPS-1))));
            end
        end
        s_tvalid <= 1'b0;

        wait (readings_due == 0);
        repeat (20) @(posedge aclk);
        $display("Sent %0d frames, %0d of them cell frames; checked %0d readings.",
                 frames_sent, cell_frames, readings_checked);
        $display("Covered count fixing, ignored frames, stalls and a long output hold-off.");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d readings outstanding", readings_due);
        $display("TEST FAILED");
        $finish;
    end

endmodule
